// ----- src/rsp_pkg.sv -----
// Package with the function codes, size constants and the sequencer state type of the subsumption pruner.
package rsp_pkg;

  localparam logic [2:0] FUNC_SET_VAR   = 3'd0;
  localparam logic [2:0] FUNC_SET_SPEC  = 3'd1;
  localparam logic [2:0] FUNC_ADD_PRED  = 3'd2;
  localparam logic [2:0] FUNC_CLR_RULE  = 3'd3;
  localparam logic [2:0] FUNC_RUN       = 3'd4;

  localparam int unsigned CountWidth = 9;
  localparam int unsigned WordBits   = 64;
  localparam int unsigned MaxWords   = 4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_NEXT_I,
    ST_CHK_I,
    ST_LD_I,
    ST_NEXT_J,
    ST_CHK_J,
    ST_LD_J,
    ST_E_Q,
    ST_E_V,
    ST_E_S,
    ST_EMIT
  } state_e;

endpackage

// ----- src/rule_subsumption_pruner.sv -----
// Rule subsumption pruner: rule tables, covering test sequencer and keep mask output.
// Load items write directly; add-predicate reads the antecedent row, then writes it back (ST_ADD).
// A run walks rule pairs through one shared compare unit: fetching an inner rule steps through
// ST_NEXT_J, ST_CHK_J and ST_LD_J, and each covering test spends ST_E_Q on an absent predicate
// slot and ST_E_Q, ST_E_V, ST_E_S on a present one. Keep masks follow from ST_EMIT, held by any
// output stall; input stalls until the last one. Reset sweeps the tables and rule count to zero.
module rule_subsumption_pruner #(
  parameter int unsigned MAX_RULES = 256,
  parameter int unsigned MAX_PREDS = 64,
  parameter int unsigned MAX_VARS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rule_count_we_i,
  input  logic [8:0]  rule_count_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [5:0]  pred_index_i,
  input  logic [5:0]  var_id_i,
  input  logic [63:0] spec_row_i,
  input  logic [7:0]  rule_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  word_index_o,
  output logic [63:0] keep_bits_o,
  output logic        last_o
);

  // Derived sizes. Rule counters hold 0..MAX_RULES, so they can need one bit more than an index.
  localparam int unsigned RW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned NW   = $clog2(MAX_RULES + 1);
  localparam int unsigned PW   = MAX_PREDS;
  localparam int unsigned PIW  = (MAX_PREDS > 1) ? $clog2(MAX_PREDS) : 1;
  localparam int unsigned SW   = (MAX_RULES > MAX_PREDS) ? MAX_RULES : MAX_PREDS;
  localparam int unsigned CLW  = $clog2(SW);
  localparam int unsigned AXW  = (MAX_RULES > 256) ? MAX_RULES : 256;
  localparam int unsigned AXIW = $clog2(AXW);

  rsp_pkg::state_e state_q, state_d;

  // Configuration register.
  logic [8:0] count_q;

  // Tables. Variables live in flip-flops for the parallel same-variable compare and
  // in a memory copy for the addressed read.
  logic [5:0]    pv_q [MAX_PREDS];
  logic [5:0]    pv_mem [MAX_PREDS];
  logic [PW-1:0] spec_mem [MAX_PREDS];
  logic [PW-1:0] ant_mem [MAX_RULES];
  logic [MAX_RULES-1:0] alive_q, alive_d;

  logic [5:0]    pv_rd_q;
  logic [PW-1:0] spec_rd_q;
  logic [PW-1:0] ant_rd_q;

  // Sequencer registers.
  logic [CLW-1:0] clr_q, clr_d;
  logic [NW-1:0]  n_q, n_d, i_q, i_d, j_q, j_d;
  logic [PW-1:0]  mi_q, mi_d, mj_q, mj_d;
  logic           dir_q, dir_d;
  logic [PIW-1:0] q_q, q_d, p_q, p_d;
  logic [1:0]     w_q, w_d;
  logic [2:0]     words_q, words_d;
  logic [RW-1:0]  add_rule_q, add_rule_d;
  logic [PIW-1:0] add_pred_q, add_pred_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [1:0]  word_q, word_d;
  logic [63:0] keep_q, keep_d;
  logic        last_q, last_d;

  // Memory ports.
  logic           ant_we, spec_we, pv_we;
  logic [RW-1:0]  ant_waddr, ant_raddr;
  logic [PW-1:0]  ant_wdata, spec_wdata;
  logic [PIW-1:0] spec_waddr, spec_raddr, pv_waddr, pv_raddr;
  logic [5:0]     pv_wdata;

  // Helpers.
  logic           accept;
  logic           pred_ok, var_ok, rule_ok;
  logic [PIW-1:0] pred_addr;
  logic [RW-1:0]  rule_addr, i_idx, j_idx;
  logic [PW-1:0]  ma, mb, cand;
  logic [PIW-1:0] cand_low;
  logic           q_last;
  logic           cov_done, cov_true;
  logic [31:0]    n_run, words_run;
  logic [AXW-1:0] alive_ext;
  logic [63:0]    keep_calc;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != rsp_pkg::ST_IDLE);
  assign pred_ok   = (32'(pred_index_i) < MAX_PREDS);
  assign var_ok    = (32'(var_id_i) < MAX_VARS);
  assign rule_ok   = (32'(rule_index_i) < MAX_RULES);
  assign pred_addr = PIW'(pred_index_i);
  assign rule_addr = RW'(rule_index_i);
  assign i_idx     = i_q[RW-1:0];
  assign j_idx     = j_q[RW-1:0];
  assign q_last    = (32'(q_q) == MAX_PREDS - 1);

  // Direction zero asks whether the outer rule covers the inner one; direction one the reverse.
  assign ma = dir_q ? mj_q : mi_q;
  assign mb = dir_q ? mi_q : mj_q;

  // Predicates of the covering rule that share the variable of predicate q.
  always_comb begin
    for (int k = 0; k < MAX_PREDS; k++) begin
      cand[k] = ma[k] && (pv_q[k] == pv_rd_q);
    end
  end

  always_comb begin
    cand_low = '0;
    for (int k = MAX_PREDS - 1; k >= 0; k--) begin
      if (cand[k]) begin
        cand_low = PIW'(k);
      end
    end
  end

  // Effective rule count and number of masks for a run.
  always_comb begin
    n_run = (32'(count_q) > MAX_RULES) ? MAX_RULES : 32'(count_q);
    words_run = (n_run + 32'd63) >> 6;
    if (words_run == 32'd0) begin
      words_run = 32'd1;
    end
    if (words_run > rsp_pkg::MaxWords) begin
      words_run = rsp_pkg::MaxWords;
    end
  end

  // Keep mask of the current word; rules at or above the count read as zero.
  assign alive_ext = AXW'(alive_q);
  always_comb begin
    for (int k = 0; k < rsp_pkg::WordBits; k++) begin
      keep_calc[k] = (32'({w_q, 6'(k)}) < 32'(n_q)) && alive_ext[AXIW'({w_q, 6'(k)})];
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    mi_d        = mi_q;
    mj_d        = mj_q;
    dir_d       = dir_q;
    q_d         = q_q;
    p_d         = p_q;
    w_d         = w_q;
    words_d     = words_q;
    add_rule_d  = add_rule_q;
    add_pred_d  = add_pred_q;
    alive_d     = alive_q;
    out_valid_d = out_valid_q && out_stall_i;
    word_d      = word_q;
    keep_d      = keep_q;
    last_d      = last_q;
    ant_we      = 1'b0;
    ant_waddr   = rule_addr;
    ant_wdata   = '0;
    ant_raddr   = rule_addr;
    spec_we     = 1'b0;
    spec_waddr  = pred_addr;
    spec_wdata  = spec_row_i[PW-1:0];
    spec_raddr  = p_q;
    pv_we       = 1'b0;
    pv_waddr    = pred_addr;
    pv_wdata    = var_id_i;
    pv_raddr    = q_q;
    cov_done    = 1'b0;
    cov_true    = 1'b0;

    unique case (state_q)
      rsp_pkg::ST_CLEAR: begin
        ant_we     = 1'b1;
        ant_waddr  = RW'(clr_q);
        spec_we    = 1'b1;
        spec_waddr = PIW'(clr_q);
        spec_wdata = '0;
        pv_we      = 1'b1;
        pv_waddr   = PIW'(clr_q);
        pv_wdata   = '0;
        clr_d      = clr_q + 1'b1;
        if (32'(clr_q) == SW - 1) begin
          state_d = rsp_pkg::ST_IDLE;
        end
      end
      rsp_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            rsp_pkg::FUNC_SET_VAR: begin
              pv_we = pred_ok && var_ok;
            end
            rsp_pkg::FUNC_SET_SPEC: begin
              spec_we = pred_ok;
            end
            rsp_pkg::FUNC_ADD_PRED: begin
              add_rule_d = rule_addr;
              add_pred_d = pred_addr;
              if (pred_ok && rule_ok) begin
                state_d = rsp_pkg::ST_ADD;
              end
            end
            rsp_pkg::FUNC_CLR_RULE: begin
              ant_we = rule_ok;
            end
            rsp_pkg::FUNC_RUN: begin
              n_d     = NW'(n_run);
              i_d     = NW'(n_run);
              words_d = 3'(words_run);
              w_d     = '0;
              for (int k = 0; k < MAX_RULES; k++) begin
                alive_d[k] = (k < n_run);
              end
              state_d = rsp_pkg::ST_NEXT_I;
            end
            default: begin
            end
          endcase
        end
      end
      rsp_pkg::ST_ADD: begin
        ant_we    = 1'b1;
        ant_waddr = add_rule_q;
        ant_wdata = ant_rd_q | (PW'(1) << add_pred_q);
        state_d   = rsp_pkg::ST_IDLE;
      end
      rsp_pkg::ST_NEXT_I: begin
        if (i_q == '0) begin
          state_d = rsp_pkg::ST_EMIT;
        end else begin
          i_d     = i_q - 1'b1;
          state_d = rsp_pkg::ST_CHK_I;
        end
      end
      rsp_pkg::ST_CHK_I: begin
        ant_raddr = i_idx;
        state_d   = alive_q[i_idx] ? rsp_pkg::ST_LD_I : rsp_pkg::ST_NEXT_I;
      end
      rsp_pkg::ST_LD_I: begin
        mi_d    = ant_rd_q;
        j_d     = i_q;
        state_d = rsp_pkg::ST_NEXT_J;
      end
      rsp_pkg::ST_NEXT_J: begin
        if (j_q == '0) begin
          state_d = rsp_pkg::ST_NEXT_I;
        end else begin
          j_d     = j_q - 1'b1;
          state_d = rsp_pkg::ST_CHK_J;
        end
      end
      rsp_pkg::ST_CHK_J: begin
        ant_raddr = j_idx;
        state_d   = alive_q[j_idx] ? rsp_pkg::ST_LD_J : rsp_pkg::ST_NEXT_J;
      end
      rsp_pkg::ST_LD_J: begin
        mj_d    = ant_rd_q;
        dir_d   = 1'b0;
        q_d     = '0;
        state_d = rsp_pkg::ST_E_Q;
      end
      rsp_pkg::ST_E_Q: begin
        // Skip predicates absent from the covered rule; fetch the variable of a present one.
        if (mb[q_q]) begin
          state_d = rsp_pkg::ST_E_V;
        end else if (q_last) begin
          cov_done = 1'b1;
          cov_true = 1'b1;
        end else begin
          q_d = q_q + 1'b1;
        end
      end
      rsp_pkg::ST_E_V: begin
        if (cand == '0) begin
          cov_done = 1'b1;
        end else begin
          p_d        = cand_low;
          spec_raddr = cand_low;
          state_d    = rsp_pkg::ST_E_S;
        end
      end
      rsp_pkg::ST_E_S: begin
        if ((p_q != q_q) && !spec_rd_q[q_q]) begin
          cov_done = 1'b1;
        end else if (q_last) begin
          cov_done = 1'b1;
          cov_true = 1'b1;
        end else begin
          q_d     = q_q + 1'b1;
          state_d = rsp_pkg::ST_E_Q;
        end
      end
      rsp_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          word_d      = w_q;
          keep_d      = keep_calc;
          last_d      = (3'(w_q) + 3'd1 == words_q);
          w_d         = w_q + 1'b1;
          if (3'(w_q) + 3'd1 == words_q) begin
            state_d = rsp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = rsp_pkg::ST_IDLE;
      end
    endcase

    // Outcome of a covering test.
    if (cov_done) begin
      if (!dir_q) begin
        if (cov_true) begin
          alive_d[j_idx] = 1'b0;
          state_d        = rsp_pkg::ST_NEXT_J;
        end else begin
          dir_d   = 1'b1;
          q_d     = '0;
          state_d = rsp_pkg::ST_E_Q;
        end
      end else begin
        if (cov_true) begin
          alive_d[i_idx] = 1'b0;
          state_d        = rsp_pkg::ST_NEXT_I;
        end else begin
          state_d = rsp_pkg::ST_NEXT_J;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsp_pkg::ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      alive_q     <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < MAX_PREDS; k++) begin
        pv_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      alive_q     <= alive_d;
      out_valid_q <= out_valid_d;
      if (rule_count_we_i) begin
        count_q <= rule_count_i;
      end
      if (pv_we) begin
        pv_q[pv_waddr] <= pv_wdata;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    i_q        <= i_d;
    j_q        <= j_d;
    mi_q       <= mi_d;
    mj_q       <= mj_d;
    dir_q      <= dir_d;
    q_q        <= q_d;
    p_q        <= p_d;
    w_q        <= w_d;
    words_q    <= words_d;
    add_rule_q <= add_rule_d;
    add_pred_q <= add_pred_d;
    word_q     <= word_d;
    keep_q     <= keep_d;
    last_q     <= last_d;
  end

  // Memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (ant_we) begin
      ant_mem[ant_waddr] <= ant_wdata;
    end
    ant_rd_q <= ant_mem[ant_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (spec_we) begin
      spec_mem[spec_waddr] <= spec_wdata;
    end
    spec_rd_q <= spec_mem[spec_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) begin
      pv_mem[pv_waddr] <= pv_wdata;
    end
    pv_rd_q <= pv_mem[pv_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign word_index_o = word_q;
  assign keep_bits_o  = keep_q;
  assign last_o       = last_q;

endmodule
